// File: rtl/core/qme_pkg.sv
// qme_pkg: types, opcodes, state codes and controller/datapath links
// for the queue machine executor; no dependencies
package qme_pkg;

    localparam int QUEUE_DEPTH    = 1024;
    localparam int QADDR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W       = QADDR_W + 1;
    localparam int REGISTER_COUNT = 26;
    localparam int RIDX_W         = 5;
    localparam int DATA_W         = 16;
    localparam int LABEL_W        = 12;
    localparam int NEXT_W         = 13;

    typedef enum logic [3:0] {
        OP_PUSH       = 4'd0,
        OP_ADD        = 4'd1,
        OP_SUB        = 4'd2,
        OP_MUL        = 4'd3,
        OP_DIV        = 4'd4,
        OP_MOD        = 4'd5,
        OP_POP_REG    = 4'd6,
        OP_PUSH_REG   = 4'd7,
        OP_PRINT_NUM  = 4'd8,
        OP_PRINT_CHAR = 4'd9,
        OP_NOP        = 4'd10,
        OP_JUMP       = 4'd11,
        OP_JZ         = 4'd12,
        OP_JEQ        = 4'd13,
        OP_JGT        = 4'd14,
        OP_QUIT       = 4'd15
    } op_t;

    localparam logic [1:0] PRINT_NONE = 2'd0;
    localparam logic [1:0] PRINT_NUM  = 2'd1;
    localparam logic [1:0] PRINT_CHAR = 2'd2;

    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_UNDER = 2'd1;
    localparam logic [1:0] FAULT_OVER  = 2'd2;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [RIDX_W-1:0]  reg_first;
        logic [RIDX_W-1:0]  reg_second;
        logic               from_register;
        logic [DATA_W-1:0]  immediate;
        logic [LABEL_W-1:0] label_position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        print_kind;
        logic [DATA_W-1:0] print_value;
        logic              branch_taken;
        logic [NEXT_W-1:0] next_index;
        logic              halted;
        logic [1:0]        fault;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_X,
        ST_WAIT_X,
        ST_POP_Y,
        ST_WAIT_Y,
        ST_DIV,
        ST_PUSH,
        ST_POP_REG,
        ST_PRINT,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the input item
        logic pop_x;      // start pop into x
        logic pop_y;      // start pop into y
        logic take_x;     // capture read data into x
        logic take_y;     // capture read data into y
        logic div_start;
        logic push;       // push the result value
        logic reg_wr;     // pop_reg write
        logic print;      // capture print value
        logic finish;     // build the result item
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        op_t  op;
        logic from_reg;
        logic halted;
        logic empty;      // value queue holds nothing
    } dp_stat_t;

endpackage

// File: rtl/core/queue_machine_executor.sv
// queue_machine_executor: one decoded queue-machine instruction per item
// div and mod use a 16-step serial divider; one item in flight, so no new item is
// accepted until the current one is through; next accept in the cycle after finish
// a waiting result holds the next in finish
// rst_n clears queue pointers, registers, halt flag; queue memory is not cleared
module queue_machine_executor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qme_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output qme_pkg::out_item_t  out_data
);
    import qme_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    out_item_t result;

    qme_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .result  (result)
    );

    qme_control u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stat        (dp_stat),
        .cmd         (dp_cmd)
    );

    assign out_data = result;

endmodule

// File: rtl/core/qme_divider.sv
// qme_divider: 16-bit restoring divider, one quotient bit a cycle
// uses qme_pkg
module qme_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [qme_pkg::DATA_W-1:0] dividend,
    input  logic [qme_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [qme_pkg::DATA_W-1:0] quotient,
    output logic [qme_pkg::DATA_W-1:0] remainder
);
    import qme_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] quot_reg, quot_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[DATA_W-1]} - {1'b0, dsr_reg};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (!trial[DATA_W])
            begin
                rem_next  = trial[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[DATA_W-2:0], quot_reg[DATA_W-1]};
                quot_next = {quot_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = (dsr_reg == '0) ? '0 : quot_reg;
    assign remainder = (dsr_reg == '0) ? '0 : rem_reg;

endmodule

// File: rtl/core/qme_datapath.sv
// qme_datapath: value queue memory, register file, halt flag, alu, result register
// uses qme_pkg and qme_divider
module qme_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  qme_pkg::in_item_t   in_item,
    input  qme_pkg::dp_cmd_t    cmd,
    output qme_pkg::dp_stat_t   stat,
    output qme_pkg::out_item_t  result
);
    import qme_pkg::*;

    logic [DATA_W-1:0]   queue_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [QADDR_W-1:0]  head_reg, tail_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic [DATA_W-1:0]   regs_reg [REGISTER_COUNT];
    logic                halt_reg;
    in_item_t            item_reg;
    logic [DATA_W-1:0]   x_reg, y_reg;
    logic [1:0]          fault_reg;
    logic [1:0]          pkind_reg;
    logic [DATA_W-1:0]   pval_reg;
    out_item_t           result_reg;
    logic                empty, full;
    logic [DATA_W-1:0]   ra_val, rb_val, alu, push_val;
    logic [2*DATA_W-1:0] prod;
    logic                div_done;
    logic [DATA_W-1:0]   quo, rem;
    logic                taken;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign ra_val = (item_reg.reg_first < RIDX_W'(REGISTER_COUNT))
                    ? regs_reg[item_reg.reg_first] : '0;
    assign rb_val = (item_reg.reg_second < RIDX_W'(REGISTER_COUNT))
                    ? regs_reg[item_reg.reg_second] : '0;
    assign prod = x_reg * y_reg;

    qme_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (x_reg),
        .divisor   (y_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        case (op_t'(item_reg.cmd))
            OP_ADD:  alu = x_reg + y_reg;
            OP_SUB:  alu = x_reg - y_reg;
            OP_MUL:  alu = prod[DATA_W-1:0];
            OP_DIV:  alu = quo;
            OP_MOD:  alu = rem;
            default: alu = '0;
        endcase
        case (op_t'(item_reg.cmd))
            OP_PUSH:     push_val = item_reg.immediate;
            OP_PUSH_REG: push_val = ra_val;
            default:     push_val = alu;
        endcase
        case (op_t'(item_reg.cmd))
            OP_JUMP: taken = 1'b1;
            OP_JZ:   taken = (ra_val == '0);
            OP_JEQ:  taken = (ra_val == rb_val);
            OP_JGT:  taken = (ra_val > rb_val);
            default: taken = 1'b0;
        endcase
    end

    // queue memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
            queue_mem[tail_reg] <= push_val;
        rd_data_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            halt_reg  <= 1'b0;
            fault_reg <= FAULT_OK;
            for (int i = 0; i < REGISTER_COUNT; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            if (cmd.load)
                fault_reg <= FAULT_OK;
            if ((cmd.pop_x || cmd.pop_y) && empty)
                fault_reg <= FAULT_UNDER;
            if ((cmd.pop_x || cmd.pop_y) && !empty)
            begin
                head_reg  <= head_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.push)
            begin
                if (full)
                begin
                    if (fault_reg == FAULT_OK)
                        fault_reg <= FAULT_OVER;
                end
                else
                begin
                    tail_reg  <= tail_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.reg_wr && item_reg.reg_first < RIDX_W'(REGISTER_COUNT))
                regs_reg[item_reg.reg_first] <= x_reg;
            if (cmd.finish && op_t'(item_reg.cmd) == OP_QUIT)
                halt_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= in_item;
            pkind_reg <= PRINT_NONE;
            pval_reg  <= '0;
        end
        // pop of an empty queue reads as zero
        if (cmd.pop_x)
            x_reg <= '0;
        if (cmd.pop_y)
            y_reg <= '0;
        if (cmd.take_x)
            x_reg <= rd_data_reg;
        if (cmd.take_y)
            y_reg <= rd_data_reg;
        if (cmd.print)
        begin
            if (op_t'(item_reg.cmd) == OP_PRINT_NUM)
            begin
                pkind_reg <= PRINT_NUM;
                pval_reg  <= item_reg.from_register ? ra_val : x_reg;
            end
            else
            begin
                pkind_reg <= PRINT_CHAR;
                pval_reg  <= {8'd0, item_reg.from_register ? ra_val[7:0] : x_reg[7:0]};
            end
        end
        if (cmd.finish)
        begin
            result_reg.print_kind   <= pkind_reg;
            result_reg.print_value  <= pval_reg;
            result_reg.branch_taken <= taken && !halt_reg;
            result_reg.next_index   <= (taken && !halt_reg)
                ? NEXT_W'({1'b0, item_reg.label_position} + NEXT_W'(1)) : '0;
            result_reg.halted       <= halt_reg || (op_t'(item_reg.cmd) == OP_QUIT);
            result_reg.fault        <= halt_reg ? FAULT_OK : fault_reg;
        end
    end

    // x_reg and y_reg capture on take only after a successful pop; the controller tracks that
    assign stat.div_done = div_done;
    assign stat.op       = op_t'(item_reg.cmd);
    assign stat.from_reg = item_reg.from_register;
    assign stat.halted   = halt_reg;
    assign stat.empty    = empty;
    assign result        = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCOUNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QADDR_W'(tail_reg - head_reg) == count_reg[QADDR_W-1:0])
        else $error("queue pointers disagree with count");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");
`endif

endmodule

// File: rtl/core/qme_control.sv
// qme_control: sequencer for one instruction, handshake on both channels
// uses qme_pkg
module qme_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  qme_pkg::dp_stat_t  stat,
    output qme_pkg::dp_cmd_t   cmd
);
    import qme_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   empty_at_pop_reg, empty_at_pop_next;
    logic   div_sent_reg, div_sent_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            empty_at_pop_reg <= 1'b0;
            div_sent_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            empty_at_pop_reg <= empty_at_pop_next;
            div_sent_reg     <= div_sent_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        empty_at_pop_next = empty_at_pop_reg;
        div_sent_next     = div_sent_reg;
        cmd               = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_POP_X;
                end
            end
            ST_POP_X:
            begin
                if (stat.halted)
                    state_next = ST_FINISH;
                else
                begin
                    unique case (stat.op) inside
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POP_REG:
                        begin
                            cmd.pop_x         = 1'b1;
                            empty_at_pop_next = stat.empty;
                            state_next        = ST_WAIT_X;
                        end
                        OP_PRINT_NUM, OP_PRINT_CHAR:
                        begin
                            if (stat.from_reg)
                                state_next = ST_PRINT;
                            else
                            begin
                                cmd.pop_x         = 1'b1;
                                empty_at_pop_next = stat.empty;
                                state_next        = ST_WAIT_X;
                            end
                        end
                        OP_PUSH, OP_PUSH_REG: state_next = ST_PUSH;
                        default:              state_next = ST_FINISH;
                    endcase
                end
            end
            ST_WAIT_X:
            begin
                cmd.take_x = !empty_at_pop_reg;
                unique case (stat.op) inside
                    OP_POP_REG:                  state_next = ST_POP_REG;
                    OP_PRINT_NUM, OP_PRINT_CHAR: state_next = ST_PRINT;
                    default:                     state_next = ST_POP_Y;
                endcase
            end
            ST_POP_Y:
            begin
                cmd.pop_y         = 1'b1;
                empty_at_pop_next = stat.empty;
                state_next        = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                cmd.take_y    = !empty_at_pop_reg;
                div_sent_next = 1'b0;
                if (stat.op == OP_DIV || stat.op == OP_MOD)
                    state_next = ST_DIV;
                else
                    state_next = ST_PUSH;
            end
            ST_DIV:
            begin
                // start the divider on entry, then wait for done
                if (stat.div_done)
                    state_next = ST_PUSH;
                else if (!div_sent_reg)
                begin
                    cmd.div_start = 1'b1;
                    div_sent_next = 1'b1;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_POP_REG:
            begin
                cmd.reg_wr = 1'b1;
                state_next = ST_FINISH;
            end
            ST_PRINT:
            begin
                cmd.print  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_next)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pop_x && cmd.pop_y))
        else $error("two pops in one cycle");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented after finish");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("item loaded while busy");
`endif

endmodule

// File: test/queue_machine_executor_tb.sv
// queue_machine_executor_tb: self-checking bench for the queue machine executor
// predicts results from its own queue/register model; depends on qme_pkg and the rtl
`timescale 1ns / 100ps

module queue_machine_executor_tb;
    import qme_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    queue_machine_executor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [DATA_W-1:0] fifo_mem [QUEUE_DEPTH];
    int                fifo_head, fifo_count;
    logic [DATA_W-1:0] regs [REGISTER_COUNT];
    logic              halt_seen;
    logic [1:0]        step_fault;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        error_count;
    int        results_seen;
    int        hold_cycles;
    bit        quiet_phase;
    int        op_hits [16];

    function automatic logic [DATA_W-1:0] fifo_pop();
        logic [DATA_W-1:0] v;
        if (fifo_count == 0)
        begin
            if (step_fault == FAULT_OK) step_fault = FAULT_UNDER;
            return '0;
        end
        v = fifo_mem[fifo_head];
        fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
        fifo_count--;
        return v;
    endfunction

    function automatic void fifo_push(logic [DATA_W-1:0] v);
        if (fifo_count >= QUEUE_DEPTH)
        begin
            if (step_fault == FAULT_OK) step_fault = FAULT_OVER;
            return;
        end
        fifo_mem[(fifo_head + fifo_count) % QUEUE_DEPTH] = v;
        fifo_count++;
    endfunction

    function automatic logic [DATA_W-1:0] reg_rd(logic [RIDX_W-1:0] idx);
        return (idx < REGISTER_COUNT) ? regs[idx] : '0;
    endfunction

    function automatic out_item_t execute_instr(in_item_t it);
        out_item_t         r;
        logic [DATA_W-1:0] x, y, v;
        logic [31:0]       wide;
        r = '0;
        step_fault = FAULT_OK;
        if (!halt_seen)
        begin
            case (op_t'(it.cmd)) inside
                OP_PUSH: fifo_push(it.immediate);
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                begin
                    x = fifo_pop();
                    y = fifo_pop();
                    case (op_t'(it.cmd))
                        OP_ADD: wide = x + y;
                        OP_SUB: wide = x - y;
                        OP_MUL: wide = x * y;
                        OP_DIV: wide = (y != 0) ? x / y : 0;
                        default: wide = (y != 0) ? x % y : 0;
                    endcase
                    fifo_push(wide[DATA_W-1:0]);
                end
                OP_POP_REG:
                begin
                    v = fifo_pop();
                    if (it.reg_first < REGISTER_COUNT) regs[it.reg_first] = v;
                end
                OP_PUSH_REG: fifo_push(reg_rd(it.reg_first));
                OP_PRINT_NUM, OP_PRINT_CHAR:
                begin
                    v = it.from_register ? reg_rd(it.reg_first) : fifo_pop();
                    if (op_t'(it.cmd) == OP_PRINT_NUM)
                    begin
                        r.print_kind  = PRINT_NUM;
                        r.print_value = v;
                    end
                    else
                    begin
                        r.print_kind  = PRINT_CHAR;
                        r.print_value = {8'h00, v[7:0]};
                    end
                end
                OP_JUMP: r.branch_taken = 1'b1;
                OP_JZ:   r.branch_taken = (reg_rd(it.reg_first) == 0);
                OP_JEQ:  r.branch_taken = (reg_rd(it.reg_first) == reg_rd(it.reg_second));
                OP_JGT:  r.branch_taken = (reg_rd(it.reg_first) > reg_rd(it.reg_second));
                OP_QUIT: halt_seen = 1'b1;
                default: ;
            endcase
        end
        if (r.branch_taken) r.next_index = NEXT_W'(it.label_position) + 1'b1;
        r.halted = halt_seen;
        r.fault  = step_fault;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    function automatic in_item_t make_instr(op_t op);
        in_item_t it;
        it.cmd            = op;
        it.reg_first      = RIDX_W'($urandom_range(0, 31));
        it.reg_second     = RIDX_W'($urandom_range(0, 31));
        // mostly valid register indexes
        if ($urandom_range(0, 9) != 0) it.reg_first = RIDX_W'($urandom_range(0, 25));
        if ($urandom_range(0, 9) != 0) it.reg_second = RIDX_W'($urandom_range(0, 25));
        it.from_register  = 1'($urandom_range(0, 1));
        it.immediate      = DATA_W'($urandom);
        if ($urandom_range(0, 7) == 0) it.immediate = DATA_W'($urandom_range(0, 3));
        it.label_position = LABEL_W'($urandom);
        return it;
    endfunction

    function automatic op_t pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30) return OP_PUSH;
        if (k < 45) return op_t'($urandom_range(OP_ADD, OP_MOD));
        if (k < 55) return OP_POP_REG;
        if (k < 65) return OP_PUSH_REG;
        if (k < 75) return op_t'($urandom_range(OP_PRINT_NUM, OP_PRINT_CHAR));
        return op_t'($urandom_range(OP_NOP, OP_JGT));
    endfunction

    task automatic add_item(in_item_t it);
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                expected_results.push_back(execute_instr(in_data));
                op_hits[in_data.cmd]++;
            end
            if (pending_items.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 29))
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", int'(out_data.print_value), 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.print_kind != want.print_kind)
                        report_mismatch("print_kind", out_data.print_kind, want.print_kind);
                    if (out_data.print_value != want.print_value)
                        report_mismatch("print_value", out_data.print_value, want.print_value);
                    if (out_data.branch_taken != want.branch_taken)
                        report_mismatch("branch_taken", out_data.branch_taken,
                                        want.branch_taken);
                    if (out_data.next_index != want.next_index)
                        report_mismatch("next_index", out_data.next_index, want.next_index);
                    if (out_data.halted != want.halted)
                        report_mismatch("halted", out_data.halted, want.halted);
                    if (out_data.fault != want.fault)
                        report_mismatch("fault", out_data.fault, want.fault);
                end
                results_seen++;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                out_stall <= !quiet_phase && ($urandom_range(0, 99) < 29);
            end
        end
    end

    initial
    begin
        in_item_t it;
        for (int i = 0; i < REGISTER_COUNT; i++) regs[i] = '0;
        fifo_head = 0;
        fifo_count = 0;
        halt_seen = 1'b0;
        error_count = 0;
        results_seen = 0;
        hold_cycles = 0;
        quiet_phase = 1'b0;

        // directed: underflow on empty queue, extremes, every operation but quit
        add_item(make_instr(OP_ADD));
        add_item(make_instr(OP_POP_REG));
        it = make_instr(OP_PRINT_NUM); it.from_register = 1'b0; add_item(it);
        it = make_instr(OP_PUSH); it.immediate = 16'hffff; add_item(it);
        it = make_instr(OP_PUSH); it.immediate = 16'hffff; add_item(it);
        add_item(make_instr(OP_MUL));
        it = make_instr(OP_PUSH); it.immediate = 16'h0000; add_item(it);
        it = make_instr(OP_PUSH); it.immediate = 16'h1234; add_item(it);
        add_item(make_instr(OP_DIV));              // divide by zero
        it = make_instr(OP_PUSH); it.immediate = 16'h0000; add_item(it);
        it = make_instr(OP_PUSH); it.immediate = 16'hfff7; add_item(it);
        add_item(make_instr(OP_MOD));              // modulo by zero
        it = make_instr(OP_PUSH); it.immediate = 16'h0001; add_item(it);
        add_item(make_instr(OP_SUB));
        it = make_instr(OP_POP_REG); it.reg_first = 25; add_item(it);
        it = make_instr(OP_POP_REG); it.reg_first = 31; add_item(it);  // ignored write
        it = make_instr(OP_PUSH_REG); it.reg_first = 25; add_item(it);
        it = make_instr(OP_PRINT_CHAR); it.from_register = 1'b1; it.reg_first = 25;
        add_item(it);
        it = make_instr(OP_JUMP); it.label_position = 12'hfff; add_item(it);
        it = make_instr(OP_JZ); it.reg_first = 0; add_item(it);
        it = make_instr(OP_JEQ); it.reg_first = 0; it.reg_second = 30; add_item(it);
        it = make_instr(OP_JGT); it.reg_first = 25; it.reg_second = 0;
        it.label_position = 12'h000; add_item(it);
        add_item(make_instr(OP_NOP));
        // push then divide; the pops take values left from earlier items, so neither underflows
        it = make_instr(OP_PUSH); it.immediate = 16'h0007; add_item(it);
        add_item(make_instr(OP_DIV));

        // random program; pushes outweigh pops in the mix so pops mostly succeed
        for (int i = 0; i < 60; i++) add_item(make_instr(pick_op()));

        // overflow: fill the queue past its depth, then pop some entries back
        for (int i = 0; i < QUEUE_DEPTH + 3; i++) add_item(make_instr(OP_PUSH));
        for (int i = 0; i < 20; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                it = make_instr(OP_PRINT_NUM);
            else
                it = make_instr(OP_POP_REG);
            it.from_register = 1'b0;
            add_item(it);
        end

        // quit, then a few ignored instructions
        add_item(make_instr(OP_QUIT));
        for (int i = 0; i < 6; i++) add_item(make_instr(pick_op()));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // long stall on the result side while items keep coming
        repeat (50) @(posedge clk);
        hold_cycles = 300;
        wait (hold_cycles == 0);
        // stretch with no idling
        quiet_phase = 1'b1;
        repeat (400) @(posedge clk);
        quiet_phase = 1'b0;

        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (40) @(posedge clk);
        $display("ran %0d results; quit seen %0d, div %0d, mod %0d, overflow fill included",
                 results_seen, op_hits[OP_QUIT], op_hits[OP_DIV], op_hits[OP_MOD]);
        if (error_count == 0 && expected_results.size() == 0)
            $display("queue_machine_executor_tb: clean");
        else
            $display("queue_machine_executor_tb: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("queue_machine_executor_tb: errors");
        $finish;
    end
endmodule
